FILE: src/dna_fragment_size_counter_top_macros.svh
// Assertion macros used by the fragment size counter top.
`ifndef DNA_FRAGMENT_SIZE_COUNTER_TOP_MACROS_SVH
`define DNA_FRAGMENT_SIZE_COUNTER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define DFSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dfsc check failed");

// Check that cons holds in the cycle after ante.
`define DFSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dfsc check failed");

`endif

FILE: src/dfsc_pkg.sv
// Shared types, widths and the chromosome length table.
package dfsc_pkg;

    localparam int CHR_W   = 6;
    localparam int POS_W   = 28;
    localparam int KEY_W   = CHR_W + POS_W;
    localparam int CNT_OUT_W = 9;
    localparam int WALK_CHR_W = CHR_W + 1;

    localparam int MAX_BREAKS_DEF      = 256;
    localparam int NUM_CHROMOSOMES_DEF = 40;

    localparam logic [POS_W-1:0] UPPER_RESET = '1;

    // Register indexes
    localparam logic REG_LOWER = 1'b0;
    localparam logic REG_UPPER = 1'b1;

    // Commands
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic consume;
        logic done;
    } t_walk_stat;

    // Length of chromosome idx+1; chromosomes without an entry have length 0
    function automatic logic [POS_W-1:0] chr_len(input logic [CHR_W-1:0] idx);
        logic [POS_W-1:0] len;
        case (idx)
            6'd0, 6'd1:   len = 28'd195471971;
            6'd2, 6'd3:   len = 28'd182113224;
            6'd4, 6'd5:   len = 28'd160039680;
            6'd6, 6'd7:   len = 28'd156508116;
            6'd8, 6'd9:   len = 28'd151834684;
            6'd10, 6'd11: len = 28'd149736546;
            6'd12, 6'd13: len = 28'd145441459;
            6'd14, 6'd15: len = 28'd129401213;
            6'd16, 6'd17: len = 28'd124595110;
            6'd18, 6'd19: len = 28'd130694993;
            6'd20, 6'd21: len = 28'd122082543;
            6'd22, 6'd23: len = 28'd120129022;
            6'd24, 6'd25: len = 28'd120421639;
            6'd26, 6'd27: len = 28'd124902244;
            6'd28, 6'd29: len = 28'd104043685;
            6'd30, 6'd31: len = 28'd98207768;
            6'd32, 6'd33: len = 28'd94987271;
            6'd34, 6'd35: len = 28'd90702639;
            6'd36, 6'd37: len = 28'd61431566;
            6'd38:        len = 28'd171031299;
            6'd39:        len = 28'd91744698;
            default:      len = '0;
        endcase
        return len;
    endfunction

endpackage

FILE: src/dfsc_cell.sv
// One cell of the sorted break chain: holds one {chromosome, position} key.
module dfsc_cell (
    input  logic                          i_clk,
    input  dfsc_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_valid,
    input  logic [dfsc_pkg::KEY_W-1:0]    i_new_key,
    input  logic [dfsc_pkg::KEY_W-1:0]    i_prev_key,
    input  logic                          i_prev_gt,
    input  logic [dfsc_pkg::KEY_W-1:0]    i_next_key,
    output logic [dfsc_pkg::KEY_W-1:0]    o_key,
    output logic                          o_gt
);

    logic [dfsc_pkg::KEY_W-1:0] r_key;
    logic [dfsc_pkg::KEY_W-1:0] n_key;

    // Empty cells and larger keys move aside for the new key
    assign o_gt  = !i_valid || (r_key > i_new_key);
    assign o_key = r_key;

    // Keep, take the new key, take the left neighbor, or drain from the right
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && o_gt) begin
            n_key = i_prev_gt ? i_prev_key : i_new_key;
        end else if (i_ctl.shift) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

FILE: src/dfsc_walk.sv
// Finish sequencer: walks chromosomes and the chain head, counting fragments.
module dfsc_walk #(
    parameter int NUM_CHROMOSOMES = dfsc_pkg::NUM_CHROMOSOMES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_head_valid,
    input  logic [dfsc_pkg::KEY_W-1:0]       i_head_key,
    input  logic [dfsc_pkg::POS_W-1:0]       i_lower,
    input  logic [dfsc_pkg::POS_W-1:0]       i_upper,
    output dfsc_pkg::t_walk_stat             o_stat,
    output logic [dfsc_pkg::CNT_OUT_W-1:0]   o_total
);

    localparam int CW = dfsc_pkg::WALK_CHR_W;
    localparam int PW = dfsc_pkg::POS_W;

    logic                               r_busy;
    logic [CW-1:0]                      r_chr;
    logic [PW-1:0]                      r_prev;
    logic                               r_end_used;
    logic [dfsc_pkg::CNT_OUT_W-1:0]     r_total;

    logic [PW-1:0]                      len;
    logic [PW-1:0]                      head_pos;
    logic                               head_match;
    logic                               past_last;
    logic                               end_first;
    logic [PW-1:0]                      diff;
    logic                               add_en;
    logic                               hit;

    assign len        = dfsc_pkg::chr_len(dfsc_pkg::CHR_W'(r_chr - CW'(1)));
    assign head_pos   = i_head_key[PW-1:0];
    assign head_match = i_head_valid &&
                        ({1'b0, i_head_key[dfsc_pkg::KEY_W-1:PW]} == r_chr);
    assign past_last  = r_chr > CW'(NUM_CHROMOSOMES);
    assign end_first  = !r_end_used && (len < head_pos);

    // Pick the fragment closed in this cycle
    always_comb begin
        diff   = len - r_prev;
        add_en = 1'b0;
        if (r_busy && !past_last) begin
            if (head_match) begin
                add_en = 1'b1;
                diff   = end_first ? (len - r_prev) : (head_pos - r_prev);
            end else begin
                add_en = !r_end_used;
            end
        end
    end

    assign hit = add_en && (diff >= i_lower) && (diff <= i_upper);

    assign o_stat.consume = r_busy && !past_last && head_match && !end_first;
    assign o_stat.done    = r_busy && past_last;
    assign o_total        = r_total;

    // Advance one break or one chromosome end per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_stat.done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_chr      <= CW'(1);
            r_prev     <= '0;
            r_end_used <= 1'b0;
            r_total    <= '0;
        end else if (r_busy && !past_last) begin
            if (hit && (r_total != '1)) begin
                r_total <= r_total + dfsc_pkg::CNT_OUT_W'(1);
            end
            if (head_match) begin
                if (end_first) begin
                    r_prev     <= len;
                    r_end_used <= 1'b1;
                end else begin
                    r_prev <= head_pos;
                end
            end else begin
                r_chr      <= r_chr + CW'(1);
                r_prev     <= '0;
                r_end_used <= 1'b0;
            end
        end
    end

endmodule

FILE: src/dna_fragment_size_counter_top.sv
// Fragment size counter top: sorted break chain, finish walker, output register.
//
//  Channel   Dir  Bus                          Contents
//  s_axis    in   tuser[0], tdata[39:0]        cmd; chromosome_id, position
//  m_axis    out  tdata[15:0]                  fragment_count, overflow
//  cfg       in   i_cfg_we/addr/data           lower_threshold, upper_threshold
//
// An add beat drops its key into its sorted place in the cell chain.
// A finish beat starts the walker, which steps through the chromosomes and the breaks at the
// chain head, closing fragments as it goes; no beat enters then, nor while the result waits
// for the output register to free up.
// Adds are taken while a result waits in the output register.
// Reset is synchronous, active low; no clearing pass is needed.
module dna_fragment_size_counter_top #(
    parameter int MAX_BREAKS      = dfsc_pkg::MAX_BREAKS_DEF,
    parameter int NUM_CHROMOSOMES = dfsc_pkg::NUM_CHROMOSOMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [5:0] chromosome_id, [33:6] position, rest zero
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [8:0] fragment_count, [9] overflow, rest zero
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [27:0] i_cfg_data
);

`include "dna_fragment_size_counter_top_macros.svh"

    localparam int CNT_W = $clog2(MAX_BREAKS + 1);
    localparam int KW    = dfsc_pkg::KEY_W;
    localparam int PW    = dfsc_pkg::POS_W;
    localparam int OW    = dfsc_pkg::CNT_OUT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]             r_state;
    logic [CNT_W-1:0]       r_count;
    logic                   r_dropped;
    logic [PW-1:0]          r_lower;
    logic [PW-1:0]          r_upper;
    logic                   r_out_valid;
    logic [OW-1:0]          r_out_count;
    logic                   r_out_ovf;

    logic                   in_beat;
    logic                   add_beat;
    logic                   fin_beat;
    logic [dfsc_pkg::CHR_W-1:0] in_chr;
    logic                   chr_ok;
    logic                   full;
    logic [KW-1:0]          new_key;
    dfsc_pkg::t_cell_ctl    cell_ctl;
    dfsc_pkg::t_walk_stat   walk_stat;
    logic [OW-1:0]          walk_total;
    logic                   out_free;

    logic [KW-1:0]          cell_key [MAX_BREAKS];
    logic                   cell_gt  [MAX_BREAKS];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign add_beat = in_beat && (s_axis_tuser[0] == dfsc_pkg::CMD_ADD);
    assign fin_beat = in_beat && (s_axis_tuser[0] == dfsc_pkg::CMD_FINISH);
    assign in_chr   = s_axis_tdata[5:0];
    assign chr_ok   = (in_chr != '0) && ({1'b0, in_chr} <= 7'(NUM_CHROMOSOMES));
    assign full     = (r_count == CNT_W'(MAX_BREAKS));
    assign new_key  = {in_chr, s_axis_tdata[33:6]};

    assign cell_ctl.ins   = add_beat && chr_ok && !full;
    assign cell_ctl.shift = walk_stat.consume;

    // Sorted chain of break cells
    for (genvar g = 0; g < MAX_BREAKS; g++) begin : g_cell
        logic [KW-1:0] prev_key;
        logic          prev_gt;
        logic [KW-1:0] next_key;
        if (g == 0) begin : g_head
            assign prev_key = new_key;
            assign prev_gt  = 1'b0;
        end else begin : g_body
            assign prev_key = cell_key[g-1];
            assign prev_gt  = cell_gt[g-1];
        end
        if (g == MAX_BREAKS - 1) begin : g_tail
            assign next_key = cell_key[g];
        end else begin : g_mid
            assign next_key = cell_key[g+1];
        end
        dfsc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_valid    (CNT_W'(g) < r_count),
            .i_new_key  (new_key),
            .i_prev_key (prev_key),
            .i_prev_gt  (prev_gt),
            .i_next_key (next_key),
            .o_key      (cell_key[g]),
            .o_gt       (cell_gt[g])
        );
    end

    dfsc_walk #(
        .NUM_CHROMOSOMES (NUM_CHROMOSOMES)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (fin_beat),
        .i_head_valid (r_count != '0),
        .i_head_key   (cell_key[0]),
        .i_lower      (r_lower),
        .i_upper      (r_upper),
        .o_stat       (walk_stat),
        .o_total      (walk_total)
    );

    // Write threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= dfsc_pkg::UPPER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dfsc_pkg::REG_LOWER: r_lower <= i_cfg_data;
                dfsc_pkg::REG_UPPER: r_upper <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;

    // Sequence adds, finish walk and result hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (cell_ctl.ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (walk_stat.consume) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (add_beat && chr_ok && full) begin
                r_dropped <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (fin_beat) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (walk_stat.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state   <= S_IDLE;
                        r_dropped <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hold the result until the downstream takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_out_count <= walk_total;
            r_out_ovf   <= r_dropped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_ovf, r_out_count};

    `DFSC_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_BREAKS))
    `DFSC_ASSERT_NEXT(a_walk_drains, r_state == S_WALK, r_count <= $past(r_count))
    `DFSC_ASSERT_SAME(a_emit_empty, r_state == S_EMIT, r_count == '0)
    `DFSC_ASSERT_SAME(a_consume_in_walk, walk_stat.consume, (r_state == S_WALK) && (r_count != '0))

endmodule

FILE: bench/dna_fragment_size_counter_top_tb.sv
// Self-checking stream testbench for the DNA fragment size counter top level.
module dna_fragment_size_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHR          = dfsc_pkg::NUM_CHROMOSOMES_DEF;
    localparam int STORE_DEPTH      = dfsc_pkg::MAX_BREAKS_DEF;
    localparam int unsigned COUNT_SAT = 511;
    localparam logic [dfsc_pkg::POS_W-1:0] POS_MAX = '1;
    localparam int ADD_SETTLE       = 8;     // margin for the last add to land in its cell
    localparam int DRAIN_CYCLES     = 400;   // finish walk over a full store plus margin
    localparam int IDLE_PCT         = 17;

    // Chromosome lengths in base pairs, chromosome 1 first
    localparam logic [dfsc_pkg::POS_W-1:0] CHROM_LEN [NUM_CHR] = '{
        28'd195471971, 28'd195471971, 28'd182113224, 28'd182113224, 28'd160039680,
        28'd160039680, 28'd156508116, 28'd156508116, 28'd151834684, 28'd151834684,
        28'd149736546, 28'd149736546, 28'd145441459, 28'd145441459, 28'd129401213,
        28'd129401213, 28'd124595110, 28'd124595110, 28'd130694993, 28'd130694993,
        28'd122082543, 28'd122082543, 28'd120129022, 28'd120129022, 28'd120421639,
        28'd120421639, 28'd124902244, 28'd124902244, 28'd104043685, 28'd104043685,
        28'd98207768,  28'd98207768,  28'd94987271,  28'd94987271,  28'd90702639,
        28'd90702639,  28'd61431566,  28'd61431566,  28'd171031299, 28'd91744698
    };

    typedef struct packed {
        logic [dfsc_pkg::CNT_OUT_W-1:0] count;
        logic                           overflow;
    } t_frag_result;

    // Sorted break store, threshold window and the queue of expected fragment counts
    class t_fragment_ledger;
        logic [dfsc_pkg::KEY_W-1:0] sorted_breaks[$];
        logic                       dropped;
        logic [dfsc_pkg::POS_W-1:0] lower_bp;
        logic [dfsc_pkg::POS_W-1:0] upper_bp;
        t_frag_result               pending_counts[$];
        int unsigned                mismatches;
        int unsigned                results_seen;

        function new();
            dropped      = 1'b0;
            lower_bp     = '0;
            upper_bp     = POS_MAX;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_window(input logic [dfsc_pkg::POS_W-1:0] lo,
                                 input logic [dfsc_pkg::POS_W-1:0] hi);
            lower_bp = lo;
            upper_bp = hi;
        endfunction

        function int unsigned in_window(input logic [dfsc_pkg::POS_W-1:0] len);
            return (len >= lower_bp && len <= upper_bp) ? 1 : 0;
        endfunction

        // Chromosome number of a stored key
        function logic [dfsc_pkg::CHR_W-1:0] key_chr(input logic [dfsc_pkg::KEY_W-1:0] key);
            return key[dfsc_pkg::KEY_W-1:dfsc_pkg::POS_W];
        endfunction

        // Cut each chromosome at 0, its breaks and its length; count fragments in the window
        function int unsigned tally_fragments();
            int unsigned                total;
            int unsigned                idx;
            logic [dfsc_pkg::POS_W-1:0] len;
            logic [dfsc_pkg::POS_W-1:0] prev;
            logic [dfsc_pkg::POS_W-1:0] cut;
            bit                         end_used;
            total = 0;
            idx   = 0;
            for (int c = 1; c <= NUM_CHR; c++) begin
                len      = CHROM_LEN[c-1];
                prev     = '0;
                end_used = 1'b0;
                while (idx < sorted_breaks.size() && key_chr(sorted_breaks[idx]) < c)
                    idx++;
                while (idx < sorted_breaks.size() && key_chr(sorted_breaks[idx]) == c) begin
                    cut = sorted_breaks[idx][dfsc_pkg::POS_W-1:0];
                    // the chromosome end sorts among the breaks past it
                    if (!end_used && len < cut) begin
                        total += in_window(len - prev);
                        prev     = len;
                        end_used = 1'b1;
                    end
                    total += in_window(cut - prev);
                    prev = cut;
                    idx++;
                end
                if (!end_used)
                    total += in_window(len - prev);
            end
            return (total > COUNT_SAT) ? COUNT_SAT : total;
        endfunction

        // Note one accepted input beat
        function void take_beat(input logic cmd, input logic [dfsc_pkg::CHR_W-1:0] chr,
                                input logic [dfsc_pkg::POS_W-1:0] pos);
            logic [dfsc_pkg::KEY_W-1:0] key;
            int                         slot;
            t_frag_result               res;
            if (cmd == dfsc_pkg::CMD_FINISH) begin
                res.count    = dfsc_pkg::CNT_OUT_W'(tally_fragments());
                res.overflow = dropped;
                pending_counts.insert(pending_counts.size(), res);
                sorted_breaks.delete();
                dropped = 1'b0;
            end else if (chr != 0 && chr <= NUM_CHR) begin
                if (sorted_breaks.size() >= STORE_DEPTH) begin
                    dropped = 1'b1;
                end else begin
                    key  = {chr, pos};
                    slot = sorted_breaks.size();
                    while (slot > 0 && sorted_breaks[slot-1] > key)
                        slot--;
                    sorted_breaks.insert(slot, key);
                end
            end
        endfunction

        // Compare one output beat with the oldest expected count
        function void check_result(input logic [dfsc_pkg::CNT_OUT_W-1:0] count,
                                   input logic overflow);
            t_frag_result want;
            results_seen++;
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result: count %0d overflow %0d",
                             $realtime, count, overflow);
            end else begin
                want = pending_counts.pop_front();
                if (count !== want.count || overflow !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected count/overflow %0d/%0d, got %0d/%0d",
                                 $realtime, want.count, want.overflow, count, overflow);
                end
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;    // [5:0] chromosome_id, [33:6] position
    logic [0:0]  s_axis_tuser  = '0;    // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [8:0] fragment_count, [9] overflow
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = dfsc_pkg::REG_LOWER;
    logic [27:0] i_cfg_data    = '0;

    t_fragment_ledger ledger = new();
    bit               steady = 1'b0;      // no idling on either side while set
    int unsigned      sent_items = 0;

    dna_fragment_size_counter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watch both streams at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_result(m_axis_tdata[dfsc_pkg::CNT_OUT_W-1:0],
                                m_axis_tdata[dfsc_pkg::CNT_OUT_W]);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            ledger.take_beat(s_axis_tuser[0], s_axis_tdata[dfsc_pkg::CHR_W-1:0],
                             s_axis_tdata[dfsc_pkg::CHR_W +: dfsc_pkg::POS_W]);
    end

    // Offer one beat, with random idle cycles ahead of it; return at the falling edge
    task automatic push_beat(input logic cmd, input logic [dfsc_pkg::CHR_W-1:0] chr,
                             input logic [dfsc_pkg::POS_W-1:0] pos);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(40-dfsc_pkg::KEY_W){1'b0}}, pos, chr};
        sent_items++;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the sender until every count has come back and the last add has settled
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending_counts.size() != 0)
            @(negedge i_clk);
        repeat (ADD_SETTLE) @(negedge i_clk);
    endtask

    // Write both thresholds; only call while the block is idle
    task automatic write_window(input logic [dfsc_pkg::POS_W-1:0] lo,
                                input logic [dfsc_pkg::POS_W-1:0] hi);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= dfsc_pkg::REG_LOWER;
        i_cfg_data <= lo;
        @(negedge i_clk);
        i_cfg_addr <= dfsc_pkg::REG_UPPER;
        i_cfg_data <= hi;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.set_window(lo, hi);
    endtask

    // Send a run of adds clustered on a focus chromosome; stray ids only when noisy
    task automatic send_run(input int unsigned n_adds, input bit noisy);
        logic [dfsc_pkg::CHR_W-1:0] focus;
        logic [dfsc_pkg::CHR_W-1:0] chr;
        logic [dfsc_pkg::POS_W-1:0] pos;
        logic [dfsc_pkg::POS_W-1:0] last_pos;
        logic [dfsc_pkg::POS_W-1:0] len;
        int unsigned                k;
        focus    = dfsc_pkg::CHR_W'($urandom_range(1, NUM_CHR));
        last_pos = '0;
        for (k = 0; k < n_adds; k++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                chr = $urandom_range(0, 1) ? '0 :
                      dfsc_pkg::CHR_W'($urandom_range(NUM_CHR + 1, 63));
            else if ($urandom_range(0, 1))
                chr = focus;
            else
                chr = dfsc_pkg::CHR_W'($urandom_range(1, NUM_CHR));
            len = (chr >= 1 && chr <= NUM_CHR) ? CHROM_LEN[chr-1] : POS_MAX;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: pos = dfsc_pkg::POS_W'($urandom_range(0, len));
                5:             pos = dfsc_pkg::POS_W'($urandom);
                6:             pos = last_pos;
                7:             pos = '0;
                8:             pos = POS_MAX;
                default:       pos = dfsc_pkg::POS_W'(len + $urandom_range(0, 4) - 2);
            endcase
            last_pos = pos;
            push_beat(dfsc_pkg::CMD_ADD, chr, pos);
        end
    endtask

    initial begin
        int unsigned                phase;
        int unsigned                runs;
        int unsigned                k;
        logic [dfsc_pkg::POS_W-1:0] lo;
        logic [dfsc_pkg::POS_W-1:0] hi;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty store: each chromosome is one whole fragment
        push_beat(dfsc_pkg::CMD_FINISH, '1, '1);
        // Repeated break, break past the end, unknown chromosomes
        push_beat(dfsc_pkg::CMD_ADD, 6'd1, 28'd0);
        push_beat(dfsc_pkg::CMD_ADD, 6'd1, 28'd0);
        push_beat(dfsc_pkg::CMD_ADD, dfsc_pkg::CHR_W'(NUM_CHR), POS_MAX);
        push_beat(dfsc_pkg::CMD_ADD, 6'd0, 28'd12345);
        push_beat(dfsc_pkg::CMD_ADD, 6'd63, 28'd777);
        push_beat(dfsc_pkg::CMD_ADD, dfsc_pkg::CHR_W'(NUM_CHR + 1), 28'd5);
        push_beat(dfsc_pkg::CMD_ADD, 6'd20, 28'd1000);
        push_beat(dfsc_pkg::CMD_FINISH, 6'd0, 28'd0);
        wait_drained();

        // Count zero-length fragments only
        write_window('0, '0);
        push_beat(dfsc_pkg::CMD_ADD, 6'd3, 28'd5);
        push_beat(dfsc_pkg::CMD_ADD, 6'd3, 28'd5);
        push_beat(dfsc_pkg::CMD_ADD, 6'd39, 28'd171031299);
        push_beat(dfsc_pkg::CMD_FINISH, 6'd0, 28'd0);
        wait_drained();

        // Inverted window counts nothing
        write_window(POS_MAX, '0);
        push_beat(dfsc_pkg::CMD_ADD, 6'd2, 28'd3);
        push_beat(dfsc_pkg::CMD_FINISH, 6'd0, 28'd0);

        // Random phases: new window, then several runs each closed by a finish
        phase = 0;
        while (sent_items < 1200) begin
            wait_drained();
            case ($urandom_range(0, 7))
                0: begin lo = '0;      hi = POS_MAX; end
                1: begin lo = '0;      hi = '0;      end
                2: begin lo = POS_MAX; hi = POS_MAX; end
                3: begin
                    lo = dfsc_pkg::POS_W'($urandom_range(1000, POS_MAX));
                    hi = dfsc_pkg::POS_W'($urandom_range(0, 999));
                end
                4: begin lo = '0; hi = dfsc_pkg::POS_W'($urandom_range(0, POS_MAX)); end
                default: begin
                    lo = dfsc_pkg::POS_W'($urandom_range(0, 60000000));
                    hi = lo + dfsc_pkg::POS_W'($urandom_range(0, 120000000));
                end
            endcase
            write_window(lo, hi);
            steady = (phase == 0);
            runs = $urandom_range(2, 6);
            for (k = 0; k < runs; k++) begin
                // first run overfills the store with no idling at all
                if (phase == 0 && k == 0)
                    send_run(STORE_DEPTH + 14, 1'b0);
                else if ($urandom_range(0, 19) == 0)
                    send_run($urandom_range(STORE_DEPTH - 6, STORE_DEPTH + 14), 1'b1);
                else
                    send_run($urandom_range(0, 24), 1'b1);
                push_beat(dfsc_pkg::CMD_FINISH, dfsc_pkg::CHR_W'($urandom),
                          dfsc_pkg::POS_W'($urandom));
            end
            phase++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (ledger.mismatches == 0 && ledger.pending_counts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
